/* hdl/baee_pkg.sv */
// ----------------------------------------------------------------------------
// Block average error estimator package
// Shared types and constants: fixed-point format, register map, the request
// and status of the iterative divide/square-root unit, sequencer states.
// ----------------------------------------------------------------------------
package baee_pkg;

  localparam int FracBits = 16;

  localparam logic [15:0] BlockLengthReset = 16'd10000;
  localparam logic [15:0] NumBlocksReset   = 16'd100;

  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_NUM_BLOCKS   = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    IU_DIV,
    IU_SQRT
  } iu_op_t;

  typedef struct packed {
    logic   start;
    iu_op_t op;
  } iu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_SQ_MUL,
    ST_ACC,
    ST_MEAN_DIV,
    ST_MEAN2_DIV,
    ST_MSQ_MUL,
    ST_VAR,
    ST_Q_DIV,
    ST_SQRT,
    ST_OUT
  } seq_state_t;

endpackage

/* hdl/block_average_error_estimator_top.sv */
// ----------------------------------------------------------------------------
// Block average error estimator
// Accumulates blocks of Q16.16 samples and reports the progressive mean of
// the block averages and its statistical error after each block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/sample): one sample per request. A sample
//   that does not close a block is added to the block sum, so samples stream
//   at one per cycle within a block.
//   The sample that closes a block starts the sequencer, which runs four
//   divisions and one square root through the shared shift-subtract unit,
//   plus five steps of its own. The first block skips the error division and
//   root. in_stall stays high while the sequencer runs.
//   Output channel (out_valid/out_stall/...): one request per completed block,
//   held in an output register. While out_stall is high the held result stays
//   and samples keep flowing; only a later block end waits for the register.
//   Samples arriving after num_blocks blocks are accepted and dropped.
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 is block_length, 1 is
//   num_blocks; other indexes are ignored. Write only while idle.
//   Reset (rst, synchronous) clears all sums and counters and loads
//   block_length = 10000, num_blocks = 100.
// ----------------------------------------------------------------------------
module block_average_error_estimator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [15:0] block_number,
  output logic signed [31:0] running_mean,
  output logic        [31:0] running_error,
  output logic               final_block,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data
);
  import baee_pkg::*;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      sat_add48 = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add48 = s[47:0];
    end
  endfunction

  function automatic logic [47:0] abs48(input logic [47:0] a);
    abs48 = a[47] ? (48'd0 - a) : a;
  endfunction

  // Configuration
  logic [15:0] block_length;
  logic [15:0] num_blocks;

  // Accumulation state
  logic [15:0] samples_in_block;
  logic [47:0] block_sum;
  logic [15:0] blocks_done;
  logic [47:0] sum_of_averages;
  logic [63:0] sum_of_squares;

  // Sequencer and work registers
  seq_state_t  state, state_next;
  logic        launched;
  logic [47:0] div_num;
  logic [16:0] div_cnt;
  logic [31:0] avg;
  logic [31:0] mean;
  logic [63:0] mean2;
  logic [63:0] var_q;
  logic [31:0] err;

  // Shared units
  iu_req_t     iu_req;
  iu_stat_t    iu_stat;
  logic [63:0] iu_operand;
  logic [16:0] iu_divisor;
  logic [63:0] iu_result;
  logic [31:0] mult_a;
  logic [63:0] mult_p;

  logic        in_acc;
  logic        drop;
  logic [47:0] block_sum_new;
  logic [16:0] count;
  logic        blk_end;
  logic [16:0] n_blocks;
  logic [63:0] prod_shr;
  logic [64:0] sos_sum;
  logic        q_ovf;
  logic        out_free;

  assign cfg_ready     = 1'b1;
  assign in_acc        = in_valid && !in_stall;
  assign drop          = (blocks_done >= num_blocks);
  assign block_sum_new = sat_add48(block_sum, 48'(sample));
  assign count         = {1'b0, samples_in_block} + 17'd1;
  // A zero block length acts as one: count is never below one.
  assign blk_end       = (count >= {1'b0, block_length});
  assign n_blocks      = {1'b0, blocks_done} + 17'd1;
  assign prod_shr      = mult_p >> FracBits;
  assign sos_sum       = {1'b0, sum_of_squares} + {1'b0, prod_shr};
  assign q_ovf         = ((var_q >> (64 - FracBits)) != 64'd0);
  assign out_free      = !out_valid || !out_stall;

  baee_iter_unit u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (iu_req),
    .operand (iu_operand),
    .divisor (iu_divisor),
    .stat    (iu_stat),
    .result  (iu_result)
  );

  baee_square u_square (
    .clk (clk),
    .a   (mult_a),
    .p   (mult_p)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_acc && !drop && blk_end) state_next = ST_AVG_DIV;
      ST_AVG_DIV:   if (iu_stat.done) state_next = ST_SQ_MUL;
      ST_SQ_MUL:    state_next = ST_ACC;
      ST_ACC:       state_next = ST_MEAN_DIV;
      ST_MEAN_DIV:  if (iu_stat.done) state_next = ST_MEAN2_DIV;
      ST_MEAN2_DIV: if (iu_stat.done) state_next = ST_MSQ_MUL;
      ST_MSQ_MUL:   state_next = ST_VAR;
      ST_VAR:       state_next = (blocks_done == 16'd0) ? ST_OUT : ST_Q_DIV;
      ST_Q_DIV:     if (iu_stat.done) state_next = ST_SQRT;
      ST_SQRT: begin
        if ((!launched && q_ovf) || iu_stat.done) state_next = ST_OUT;
      end
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    iu_req.start = 1'b0;
    iu_req.op    = IU_DIV;
    iu_operand   = '0;
    iu_divisor   = '0;
    mult_a       = (state == ST_MSQ_MUL) ? mean : avg;
    in_stall     = (state != ST_IDLE);
    unique case (state)
      ST_AVG_DIV: begin
        iu_req.start = !launched;
        iu_operand   = {16'd0, abs48(div_num)};
        iu_divisor   = div_cnt;
      end
      ST_MEAN_DIV: begin
        iu_req.start = !launched;
        iu_operand   = {16'd0, abs48(sum_of_averages)};
        iu_divisor   = n_blocks;
      end
      ST_MEAN2_DIV: begin
        iu_req.start = !launched;
        iu_operand   = sum_of_squares;
        iu_divisor   = n_blocks;
      end
      ST_Q_DIV: begin
        iu_req.start = !launched;
        iu_operand   = var_q;
        iu_divisor   = {1'b0, blocks_done};
      end
      ST_SQRT: begin
        iu_req.start = !launched && !q_ovf;
        iu_req.op    = IU_SQRT;
        iu_operand   = var_q << FracBits;
      end
      ST_IDLE, ST_SQ_MUL, ST_ACC, ST_MSQ_MUL, ST_VAR, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      launched         <= 1'b0;
      block_length     <= BlockLengthReset;
      num_blocks       <= NumBlocksReset;
      samples_in_block <= '0;
      block_sum        <= '0;
      blocks_done      <= '0;
      sum_of_averages  <= '0;
      sum_of_squares   <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (iu_req.start) begin
        launched <= 1'b1;
      end else if (iu_stat.done) begin
        launched <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BLOCK_LENGTH) block_length <= cfg_data;
        else if (cfg_index == REG_NUM_BLOCKS) num_blocks <= cfg_data;
      end

      if (state == ST_IDLE && in_acc && !drop) begin
        if (blk_end) begin
          samples_in_block <= '0;
          block_sum        <= '0;
        end else begin
          samples_in_block <= count[15:0];
          block_sum        <= block_sum_new;
        end
      end

      if (state == ST_ACC) begin
        sum_of_averages <= sat_add48(sum_of_averages, 48'(signed'(avg)));
        sum_of_squares  <= sos_sum[64] ? {64{1'b1}} : sos_sum[63:0];
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_OUT && out_free) begin
        out_valid   <= 1'b1;
        blocks_done <= n_blocks[15:0];
      end
    end
  end

  // Work and output registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && blk_end) begin
      div_num <= block_sum_new;
      div_cnt <= count;
    end

    case (state)
      ST_AVG_DIV: begin
        if (iu_stat.done) avg <= div_num[47] ? (32'd0 - iu_result[31:0]) : iu_result[31:0];
      end
      ST_MEAN_DIV: begin
        if (iu_stat.done) begin
          mean <= sum_of_averages[47] ? (32'd0 - iu_result[31:0]) : iu_result[31:0];
        end
      end
      ST_MEAN2_DIV: begin
        if (iu_stat.done) mean2 <= iu_result;
      end
      ST_VAR: begin
        // Clamp a negative variance from rounding to zero.
        var_q <= (mean2 > prod_shr) ? (mean2 - prod_shr) : 64'd0;
        if (blocks_done == 16'd0) err <= '0;
      end
      ST_Q_DIV: begin
        if (iu_stat.done) var_q <= iu_result;
      end
      ST_SQRT: begin
        if (!launched && q_ovf) begin
          err <= {32{1'b1}};
        end else if (iu_stat.done) begin
          err <= iu_result[31:0];
        end
      end
      default: begin
      end
    endcase

    if (state == ST_OUT && out_free) begin
      block_number  <= blocks_done;
      running_mean  <= mean;
      running_error <= err;
      final_block   <= (n_blocks == {1'b0, num_blocks});
    end
  end

endmodule

/* hdl/baee_iter_unit.sv */
// ----------------------------------------------------------------------------
// Iterative divide / square-root unit
// Shift-subtract unit shared by all divisions and the square root: unsigned
// 64 / 17 bit restoring division, one quotient bit per cycle, and 64-bit
// integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module baee_iter_unit (
  input  logic               clk,
  input  logic               rst,
  input  baee_pkg::iu_req_t  req,
  input  logic [63:0]        operand,
  input  logic [16:0]        divisor,
  output baee_pkg::iu_stat_t stat,
  output logic [63:0]        result
);
  import baee_pkg::*;

  localparam logic [5:0] DivLast  = 6'd63;
  localparam logic [5:0] SqrtLast = 6'd31;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  iu_op_t      op;
  logic [63:0] acc;
  logic [33:0] rem;
  logic [31:0] root;

  logic [35:0] shifted;
  logic [35:0] subtrahend;
  logic [36:0] diff;
  logic        ge;

  // One shared compare-subtract serves both operations.
  always_comb begin
    if (op == IU_SQRT) begin
      shifted    = {rem, acc[63:62]};
      subtrahend = {2'b00, root, 2'b01};
    end else begin
      shifted    = {1'b0, rem, acc[63]};
      subtrahend = {19'd0, divisor};
    end
    diff = {1'b0, shifted} - {1'b0, subtrahend};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= (req.op == IU_SQRT) ? SqrtLast : DivLast;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op   <= req.op;
      acc  <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem <= ge ? diff[33:0] : shifted[33:0];
      if (op == IU_SQRT) begin
        acc  <= {acc[61:0], 2'b00};
        root <= {root[30:0], ge};
      end else begin
        acc <= {acc[62:0], ge};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = (op == IU_SQRT) ? {32'd0, root} : acc;

endmodule

/* hdl/baee_square.sv */
// ----------------------------------------------------------------------------
// Squaring unit
// Registered signed 32 x 32 bit square; the product is ready in the cycle
// after the operand is presented.
// ----------------------------------------------------------------------------
module baee_square (
  input  logic               clk,
  input  logic signed [31:0] a,
  output logic        [63:0] p
);
  import baee_pkg::*;

  logic signed [63:0] prod;

  assign prod = 64'(a) * 64'(a);

  always_ff @(posedge clk) begin
    p <= prod;
  end

endmodule

/* bench/tb_block_average_error_estimator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block average error estimator testbench
// Streams Q16.16 samples through the estimator under a series of block
// lengths and block counts. A local model predicts each block's mean and
// error as samples are accepted, and every reported block is checked against
// it. Both channels stall at random; one phase holds the output off long
// enough to back the input up.
// ----------------------------------------------------------------------------
module tb_block_average_error_estimator_top;
  import baee_pkg::*;

  localparam int IdleLimit    = 10000;
  localparam int HoldCycles   = 2000;
  localparam int SettleCycles = 20;
  localparam int RandomItems  = 1050;

  localparam longint SumMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;

  localparam logic [1:0] UnmappedRegLo = 2'd2;
  localparam logic [1:0] UnmappedRegHi = 2'd3;

  typedef struct packed {
    logic        [15:0] block_number;
    logic signed [31:0] running_mean;
    logic        [31:0] running_error;
    logic               final_block;
  } block_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [15:0] block_number;
  logic signed [31:0] running_mean;
  logic        [31:0] running_error;
  logic               final_block;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = '0;
  logic        [15:0] cfg_data = '0;

  // Estimator state as seen by the model
  int unsigned     len_cfg  = BlockLengthReset;
  int unsigned     nblk_cfg = NumBlocksReset;
  int unsigned     in_blk   = 0;
  int unsigned     done_cnt = 0;
  longint          blk_sum  = 0;
  longint          avg_sum  = 0;
  longint unsigned sq_sum   = 0;

  logic [31:0]   samples_to_send[$];
  block_report_t expected_blocks[$];
  int            items_queued   = 0;
  int            items_accepted = 0;
  int            samples_summed = 0;
  int            mismatches     = 0;
  int            idle_cycles    = 0;

  bit steady     = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;

  block_average_error_estimator_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .block_number  (block_number),
    .running_mean  (running_mean),
    .running_error (running_error),
    .final_block   (final_block),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_s48(input longint v);
    if (v > SumMax) return SumMax;
    if (v < SumMin) return SumMin;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      REG_BLOCK_LENGTH: len_cfg = val;
      REG_NUM_BLOCKS:   nblk_cfg = val;
      default: ;
    endcase
  endfunction

  // Add one sample; returns 1 with the block report when it closes a block.
  function automatic bit fold_sample(input logic signed [31:0] s, output block_report_t rep);
    int unsigned     len, cnt, idx, n;
    longint          avg, mean_v;
    longint unsigned sq, sq_next, mean2, msq, var_v, qv, err_v;
    rep = '0;
    len = (len_cfg == 0) ? 1 : len_cfg;
    if (done_cnt >= nblk_cfg) return 1'b0;
    samples_summed++;
    blk_sum = clamp_s48(blk_sum + longint'(s));
    cnt = in_blk + 1;
    if (cnt < len) begin
      in_blk = cnt & 32'hFFFF;
      return 1'b0;
    end
    // a shortened block divides by what was actually summed
    avg = blk_sum / longint'(cnt);
    blk_sum = 0;
    in_blk = 0;
    sq = $unsigned(avg * avg) >> FracBits;
    avg_sum = clamp_s48(avg_sum + avg);
    sq_next = sq_sum + sq;
    sq_sum = (sq_next < sq_sum) ? '1 : sq_next;
    idx = done_cnt;
    n = idx + 1;
    mean_v = avg_sum / longint'(n);
    mean2 = sq_sum / n;
    msq = $unsigned(mean_v * mean_v) >> FracBits;
    // rounding can push the variance below zero: clamp
    var_v = (mean2 > msq) ? mean2 - msq : 64'd0;
    if (idx == 0) begin
      err_v = 0;
    end else begin
      qv = var_v / idx;
      if ((qv >> (64 - FracBits)) != 0) err_v = 64'hFFFF_FFFF;
      else err_v = floor_sqrt(qv << FracBits);
    end
    done_cnt = n & 32'hFFFF;
    rep.block_number  = idx[15:0];
    rep.running_mean  = mean_v[31:0];
    rep.running_error = err_v[31:0];
    rep.final_block   = (n == nblk_cfg);
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_sample(input logic [31:0] center);
    case ($urandom_range(19))
      0, 1, 2: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      3, 4, 5, 6, 7, 8, 9: return $urandom();
      default: return center + $urandom_range(64) - 32;
    endcase
  endfunction

  task automatic queue_sample(input logic [31:0] v);
    samples_to_send.push_back(v);
    items_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every request is in and every block report is out.
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_blocks.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Sample driver
  always @(posedge clk) begin
    block_report_t rep;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (fold_sample(sample, rep)) expected_blocks.push_back(rep);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          in_valid <= 1'b1;
          sample   <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 30);
      if (hold_req && !hold_taken) begin
        hold_left  <= HoldCycles;
        hold_taken <= 1'b1;
      end
    end
  end

  // Report checker
  always @(posedge clk) begin
    block_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected block report: block_number %0d", block_number);
        mismatches++;
      end else begin
        want = expected_blocks.pop_front();
        if (block_number !== want.block_number) begin
          $error("block_number: expected %0d, got %0d", want.block_number, block_number);
          mismatches++;
        end
        if (running_mean !== want.running_mean) begin
          $error("running_mean: expected %0d, got %0d", want.running_mean, running_mean);
          mismatches++;
        end
        if (running_error !== want.running_error) begin
          $error("running_error: expected %0d, got %0d", want.running_error, running_error);
          mismatches++;
        end
        if (final_block !== want.final_block) begin
          $error("final_block: expected %0d, got %0d", want.final_block, final_block);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned len, nblk, count;
    logic [31:0] center;
    int          phase;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Single-sample blocks; 255 then 257 drives the variance below zero
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    write_reg(REG_NUM_BLOCKS, 16'd4);
    write_reg(UnmappedRegLo, 16'hFFFF);
    write_reg(UnmappedRegHi, 16'hA5A5);
    queue_sample(32'd255);
    queue_sample(32'd257);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h0001_2345);
    wait_idle();

    // No blocks allowed, then a count below the blocks already done
    write_reg(REG_NUM_BLOCKS, 16'd0);
    queue_sample(32'h0000_1000);
    wait_idle();
    write_reg(REG_NUM_BLOCKS, 16'd2);
    queue_sample(32'hFFFF_0000);
    wait_idle();

    // Zero length acts as one
    write_reg(REG_NUM_BLOCKS, 16'hFFFF);
    write_reg(REG_BLOCK_LENGTH, 16'd0);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0001_0000);
    wait_idle();

    // Longest block, then shorten it mid-block
    write_reg(REG_BLOCK_LENGTH, 16'hFFFF);
    queue_sample(32'hFFFE_0000);
    queue_sample(32'h8000_0001);
    queue_sample(32'hFFFF_FFF0);
    wait_idle();
    write_reg(REG_BLOCK_LENGTH, 16'd2);
    queue_sample(32'h0000_0007);
    wait_idle();

    // Negative sum truncates toward zero
    write_reg(REG_BLOCK_LENGTH, 16'd3);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0000_0000);
    wait_idle();

    samples_summed = 0;
    phase = 0;
    while (samples_summed < RandomItems) begin
      steady   = (phase == 1);
      hold_req = hold_req || (phase == 3);
      case ($urandom_range(9))
        0:          len = 0;
        1, 2, 3, 4: len = $urandom_range(1, 3);
        5, 6, 7:    len = $urandom_range(4, 12);
        8:          len = $urandom_range(13, 60);
        default:    len = 1;
      endcase
      case ($urandom_range(9))
        0:       nblk = 16'hFFFF;
        1:       nblk = $urandom_range(0, done_cnt);
        default: nblk = done_cnt + $urandom_range(1, 30);
      endcase
      // back the input up behind a long output hold
      if (phase == 3) begin
        len  = 1;
        nblk = 16'hFFFF;
      end
      write_reg(REG_BLOCK_LENGTH, len[15:0]);
      write_reg(REG_NUM_BLOCKS, nblk[15:0]);
      count  = (nblk <= done_cnt) ? 5 : $urandom_range(40, 90);
      center = $urandom_range(1) ? $urandom_range(1024) : $urandom();
      repeat (count) queue_sample(pick_sample(center));
      wait_idle();
      phase++;
    end

    steady = 1'b0;
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
